// ===== src/stok_pkg.sv =====
package stok_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [4:0] K_EOF = 5'd0;
    localparam logic [4:0] K_IDENT = 5'd1;
    localparam logic [4:0] K_NUMBER = 5'd2;
    localparam logic [4:0] K_STRING = 5'd3;
    localparam logic [4:0] K_KEYWORD0 = 5'd4;
    localparam logic [4:0] K_PUNCT0 = 5'd11;
    localparam logic [4:0] K_STR_BYTE = 5'd18;
    localparam logic [4:0] K_ERROR = 5'd19;

    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_OPEN_COMMENT = 3'd1;
    localparam logic [2:0] E_OPEN_ESCAPE = 3'd2;
    localparam logic [2:0] E_BAD_ESCAPE = 3'd3;
    localparam logic [2:0] E_OPEN_STRING = 3'd4;
    localparam logic [2:0] E_RANGE = 3'd5;
    localparam logic [2:0] E_BAD_CHAR = 3'd6;

    localparam int NUM_KW = 7;

    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"f", "u", "n", "c", "t", "i", "o", "n"},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd8, 4'd3, 4'd2, 4'd4, 4'd5, 4'd5};

    localparam logic [7:0] PUNCT [NUM_KW] = '{"(", ")", "{", "}", ";", ",", "="};

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [31:0] start_offset;
        logic [31:0] token_length;
        logic [31:0] number_value;
        logic [7:0]  char_value;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

endpackage

// ===== src/stok_if.sv =====
interface stok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_source;

    modport source (output valid, output data_byte, output end_of_source, input ready);
    modport sink (input valid, input data_byte, input end_of_source, output ready);
endinterface

interface stok_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] number_value;
    logic [7:0]  char_value;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output number_value, output char_value,
                    output error_code, output last, input ready);
    modport sink (input valid, input token_kind, input start_offset,
                  input token_length, input number_value, input char_value,
                  input error_code, input last, output ready);
endinterface

// ===== src/streaming_source_tokenizer.sv =====
// Source tokenizer: takes one source byte (or an end marker) per cycle while
// its four-entry output queue holds at most two entries, and writes the zero,
// one or two result words the byte causes into that queue. Input is held off
// at three or more entries, even while results drain; the queue depth sets
// how long a stalled consumer can be absorbed before input is held off.
module streaming_source_tokenizer
    import stok_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    stok_in_if.sink        i_in,
    stok_out_if.source     o_out
);

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_SLASH = 4'd1;
    localparam logic [3:0] M_BLOCK = 4'd2;
    localparam logic [3:0] M_LINE = 4'd3;
    localparam logic [3:0] M_IDENT = 4'd4;
    localparam logic [3:0] M_NUMBER = 4'd5;
    localparam logic [3:0] M_STRING = 4'd6;
    localparam logic [3:0] M_ESCAPE = 4'd7;
    localparam logic [3:0] M_ERROR = 4'd8;

    localparam int P = POSITION_BITS;
    localparam int V = VALUE_BITS;

    logic [3:0]   r_mode, n_mode;
    logic [P-1:0] r_pos, n_pos;
    logic [P-1:0] r_start, n_start;
    logic [V-1:0] r_acc, n_acc;
    logic         r_ovf, n_ovf;
    logic [6:0]   r_cand, n_cand;
    logic [3:0]   r_icnt, n_icnt;
    logic         r_star, n_star;

    t_result      r_q [4];
    logic [1:0]   r_wp, r_rp;
    logic [2:0]   r_cnt;

    t_result      res [2];
    logic [1:0]   nres;

    function automatic logic blank_byte(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D
            || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic dec_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic word_lead(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [31:0] off32(input logic [P-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[31:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [P:0] v);
        logic [64:0] t;
        t = 65'(v);
        return (t > 65'h0FFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
    endfunction

    function automatic logic [31:0] val32(input logic [V-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[31:0];
    endfunction

    function automatic t_result mk(input logic [4:0] kind, input logic [31:0] st,
                                   input logic [31:0] len, input logic [31:0] num,
                                   input logic [7:0] ch, input logic [2:0] err);
        t_result r;
        r.token_kind = kind;
        r.start_offset = st;
        r.token_length = len;
        r.number_value = num;
        r.char_value = ch;
        r.error_code = err;
        r.last = 1'b0;
        return r;
    endfunction

    logic          take;
    logic [7:0]    c;
    logic [P-1:0]  span;
    logic [V+3:0]  acc10;
    logic [V+3:0]  vmax;

    assign take = i_in.valid && i_in.ready;
    assign c = i_in.data_byte;
    assign span = r_pos - r_start;
    assign acc10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + (V+4)'(c - "0");
    assign vmax = {4'b0, {V{1'b1}}};

    always_comb begin
        logic       do_idle;
        logic       word_end;
        logic [4:0] kind;
        logic       hit;
        logic [7:0] ev;
        logic       ev_ok;
        n_mode = r_mode;
        n_pos = r_pos;
        n_start = r_start;
        n_acc = r_acc;
        n_ovf = r_ovf;
        n_cand = r_cand;
        n_icnt = r_icnt;
        n_star = r_star;
        nres = 2'd0;
        res[0] = '0;
        res[1] = '0;
        do_idle = 1'b0;
        word_end = 1'b0;
        kind = K_IDENT;
        hit = 1'b0;
        ev = 8'h00;
        ev_ok = 1'b1;

        for (int k = 0; k < NUM_KW; k++) begin
            if (r_cand[k] && r_icnt == KW_LEN[k]) begin
                kind = K_KEYWORD0 + 5'(k);
            end
        end

        if (i_in.end_of_source) begin
            case (r_mode)
                M_IDENT, M_NUMBER: word_end = 1'b1;
                M_SLASH: begin
                    res[nres[0]] = mk(K_ERROR, off32(r_start), '0, '0, '0, E_BAD_CHAR);
                    nres = nres + 2'd1;
                end
                M_BLOCK: begin
                    res[nres[0]] = mk(K_ERROR, off32(r_start), '0, '0, '0,
                                      E_OPEN_COMMENT);
                    nres = nres + 2'd1;
                end
                M_STRING: begin
                    res[nres[0]] = mk(K_ERROR, off32(r_start), '0, '0, '0,
                                      E_OPEN_STRING);
                    nres = nres + 2'd1;
                end
                M_ESCAPE: begin
                    res[nres[0]] = mk(K_ERROR, off32(r_start), '0, '0, '0,
                                      E_OPEN_ESCAPE);
                    nres = nres + 2'd1;
                end
                default: ;
            endcase
        end else begin
            case (r_mode)
                M_IDLE: do_idle = 1'b1;
                M_SLASH: begin
                    if (c == "*") begin
                        n_mode = M_BLOCK;
                        n_star = 1'b0;
                    end else if (c == "/") begin
                        n_mode = M_LINE;
                    end else begin
                        res[nres[0]] = mk(K_ERROR, off32(r_start), '0, '0, '0,
                                          E_BAD_CHAR);
                        nres = nres + 2'd1;
                        n_mode = M_ERROR;
                    end
                end
                M_BLOCK: begin
                    if (r_star && c == "/") begin
                        n_mode = M_IDLE;
                    end
                    n_star = (c == "*");
                end
                M_LINE: begin
                    if (c == 8'h0A) begin
                        n_mode = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (word_lead(c) || dec_digit(c)) begin
                        for (int k = 0; k < NUM_KW; k++) begin
                            if (!(r_cand[k] && r_icnt < KW_LEN[k]
                                  && KW_TEXT[k][r_icnt[2:0]] == c)) begin
                                n_cand[k] = 1'b0;
                            end
                        end
                        if (r_icnt < 4'd9) begin
                            n_icnt = r_icnt + 4'd1;
                        end
                    end else begin
                        word_end = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (dec_digit(c)) begin
                        if (!r_ovf) begin
                            if (acc10 > vmax) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_acc = acc10[V-1:0];
                            end
                        end
                    end else begin
                        word_end = 1'b1;
                        do_idle = !r_ovf;
                    end
                end
                M_STRING: begin
                    if (c == "\"") begin
                        res[nres[0]] = mk(K_STRING, off32(r_start),
                                          sat32({1'b0, span} + (P+1)'(1)), '0, '0, E_NONE);
                        nres = nres + 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == "\\") begin
                        n_mode = M_ESCAPE;
                    end else begin
                        res[nres[0]] = mk(K_STR_BYTE, off32(r_pos), 32'd1, '0, c, E_NONE);
                        nres = nres + 2'd1;
                    end
                end
                M_ESCAPE: begin
                    case (c)
                        "n": ev = 8'h0A;
                        "t": ev = 8'h09;
                        "r": ev = 8'h0D;
                        "f": ev = 8'h0C;
                        "v": ev = 8'h0B;
                        "\"": ev = 8'h22;
                        "\\": ev = 8'h5C;
                        "0": ev = 8'h00;
                        default: ev_ok = 1'b0;
                    endcase
                    if (ev_ok) begin
                        res[nres[0]] = mk(K_STR_BYTE, off32(r_pos - P'(1)), 32'd2, '0, ev,
                                          E_NONE);
                        nres = nres + 2'd1;
                        n_mode = M_STRING;
                    end else begin
                        res[nres[0]] = mk(K_ERROR, off32(r_start), '0, '0, '0,
                                          E_BAD_ESCAPE);
                        nres = nres + 2'd1;
                        n_mode = M_ERROR;
                    end
                end
                default: n_mode = M_ERROR;
            endcase
        end

        if (word_end) begin
            if (r_mode == M_IDENT) begin
                res[nres[0]] = mk(kind, off32(r_start), sat32({1'b0, span}), '0, '0,
                                  E_NONE);
                n_mode = M_IDLE;
            end else if (r_ovf) begin
                res[nres[0]] = mk(K_ERROR, off32(r_start), '0, '0, '0, E_RANGE);
                n_mode = M_ERROR;
            end else begin
                res[nres[0]] = mk(K_NUMBER, off32(r_start), sat32({1'b0, span}),
                                  val32(r_acc), '0, E_NONE);
                n_mode = M_IDLE;
            end
            nres = nres + 2'd1;
        end

        if (do_idle && !blank_byte(c)) begin
            n_start = r_pos;
            if (c == "/") begin
                n_mode = M_SLASH;
            end else if (word_lead(c)) begin
                n_mode = M_IDENT;
                for (int k = 0; k < NUM_KW; k++) begin
                    n_cand[k] = (KW_TEXT[k][0] == c);
                end
                n_icnt = 4'd1;
            end else if (dec_digit(c)) begin
                n_mode = M_NUMBER;
                n_acc = V'(c - "0");
                n_ovf = 1'b0;
            end else if (c == "\"") begin
                n_mode = M_STRING;
            end else begin
                for (int k = 0; k < NUM_KW; k++) begin
                    if (PUNCT[k] == c) begin
                        res[nres[0]] = mk(K_PUNCT0 + 5'(k), off32(r_pos), 32'd1, '0, '0,
                                          E_NONE);
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    res[nres[0]] = mk(K_ERROR, off32(r_pos), '0, '0, '0, E_BAD_CHAR);
                    n_mode = M_ERROR;
                end else begin
                    n_mode = M_IDLE;
                end
                nres = nres + 2'd1;
            end
        end

        if (i_in.end_of_source) begin
            res[nres[0]] = mk(K_EOF, off32(r_pos), '0, '0, '0, E_NONE);
            nres = nres + 2'd1;
            n_mode = M_IDLE;
            n_pos = '0;
            n_start = '0;
            n_acc = '0;
            n_ovf = 1'b0;
            n_cand = 7'h7F;
            n_icnt = 4'd0;
            n_star = 1'b0;
        end else begin
            n_pos = r_pos + P'(1);
        end

        if (nres == 2'd1) begin
            res[0].last = 1'b1;
        end else if (nres == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    logic pop;
    assign pop = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt <= 3'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos <= '0;
            r_start <= '0;
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_cand <= 7'h7F;
            r_icnt <= 4'd0;
            r_star <= 1'b0;
        end else if (take) begin
            r_mode <= n_mode;
            r_pos <= n_pos;
            r_start <= n_start;
            r_acc <= n_acc;
            r_ovf <= n_ovf;
            r_cand <= n_cand;
            r_icnt <= n_icnt;
            r_star <= n_star;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (take) begin
                if (nres != 2'd0) begin
                    r_q[r_wp] <= res[0];
                end
                if (nres == 2'd2) begin
                    r_q[r_wp + 2'd1] <= res[1];
                end
                r_wp <= r_wp + nres;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + (take ? {1'b0, nres} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    assign o_out.valid = (r_cnt != 3'd0);
    assign o_out.token_kind = r_q[r_rp].token_kind;
    assign o_out.start_offset = r_q[r_rp].start_offset;
    assign o_out.token_length = r_q[r_rp].token_length;
    assign o_out.number_value = r_q[r_rp].number_value;
    assign o_out.char_value = r_q[r_rp].char_value;
    assign o_out.error_code = r_q[r_rp].error_code;
    assign o_out.last = r_q[r_rp].last;

endmodule

// ===== bench/stok_checker.sv =====
module stok_checker
    import stok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    stok_in_if.sink    i_in_mon,
    stok_out_if.sink   i_out_mon,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        S_IDLE, S_SLASH, S_BLOCK, S_LINE, S_IDENT, S_NUMBER, S_STRING, S_ESCAPE, S_ERROR
    } t_scan;

    t_scan       scan;
    logic [31:0] pos;
    logic [31:0] tok_start;
    logic [31:0] acc;
    logic        ovf;
    logic [6:0]  kw_live;
    logic [3:0]  id_cnt;
    logic        star;

    t_result token_q[$];
    t_result step_q[$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending = token_q.size();

    function automatic logic blank_byte(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic dec_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic word_lead(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    task automatic emit(logic [4:0] kind, logic [31:0] at, logic [31:0] len,
                        logic [31:0] num, logic [7:0] ch, logic [2:0] err);
        t_result r;
        r.token_kind = kind;
        r.start_offset = at;
        r.token_length = len;
        r.number_value = num;
        r.char_value = ch;
        r.error_code = err;
        r.last = 1'b0;
        step_q.insert(step_q.size(), r);
    endtask

    task automatic raise(logic [31:0] at, logic [2:0] err);
        scan = S_ERROR;
        emit(K_ERROR, at, 32'd0, 32'd0, 8'd0, err);
    endtask

    task automatic reset_scan();
        scan = S_IDLE;
        pos = 0;
        tok_start = 0;
        acc = 0;
        ovf = 0;
        kw_live = 7'h7f;
        id_cnt = 0;
        star = 0;
    endtask

    task automatic track_keyword(logic [7:0] c);
        for (int k = 0; k < NUM_KW; k++) begin
            if (!(kw_live[k] && id_cnt < KW_LEN[k] && KW_TEXT[k][id_cnt[2:0]] == c))
                kw_live[k] = 1'b0;
        end
        if (id_cnt < 9) id_cnt++;
    endtask

    task automatic close_word();
        logic [4:0] kind;
        if (scan == S_IDENT) begin
            kind = K_IDENT;
            for (int k = 0; k < NUM_KW; k++)
                if (kw_live[k] && id_cnt == KW_LEN[k]) kind = K_KEYWORD0 + 5'(k);
            scan = S_IDLE;
            emit(kind, tok_start, pos - tok_start, 32'd0, 8'd0, E_NONE);
        end else if (ovf) begin
            raise(tok_start, E_RANGE);
        end else begin
            scan = S_IDLE;
            emit(K_NUMBER, tok_start, pos - tok_start, acc, 8'd0, E_NONE);
        end
    endtask

    task automatic scan_fresh(logic [7:0] c);
        logic hit;
        hit = 0;
        if (!blank_byte(c)) begin
            tok_start = pos;
            if (c == "/") scan = S_SLASH;
            else if (word_lead(c)) begin
                scan = S_IDENT;
                kw_live = 7'h7f;
                id_cnt = 0;
                track_keyword(c);
            end else if (dec_digit(c)) begin
                scan = S_NUMBER;
                acc = 32'(c - "0");
                ovf = 0;
            end else if (c == "\"") scan = S_STRING;
            else begin
                for (int k = 0; k < NUM_KW; k++)
                    if (PUNCT[k] == c && !hit) begin
                        hit = 1;
                        emit(K_PUNCT0 + 5'(k), pos, 32'd1, 32'd0, 8'd0, E_NONE);
                    end
                if (!hit) raise(pos, E_BAD_CHAR);
            end
        end
    endtask

    task automatic predict_word(logic [7:0] c, logic eos);
        logic [7:0]  esc;
        logic        esc_ok;
        logic [31:0] d;
        logic [32:0] slen;
        step_q.delete();
        if (eos) begin
            case (scan)
                S_IDENT, S_NUMBER: close_word();
                S_SLASH: raise(tok_start, E_BAD_CHAR);
                S_BLOCK: raise(tok_start, E_OPEN_COMMENT);
                S_STRING: raise(tok_start, E_OPEN_STRING);
                S_ESCAPE: raise(tok_start, E_OPEN_ESCAPE);
                default: ;
            endcase
            emit(K_EOF, pos, 32'd0, 32'd0, 8'd0, E_NONE);
            reset_scan();
        end else begin
            case (scan)
                S_IDLE: scan_fresh(c);
                S_SLASH: begin
                    if (c == "*") begin
                        scan = S_BLOCK;
                        star = 0;
                    end else if (c == "/") scan = S_LINE;
                    else raise(tok_start, E_BAD_CHAR);
                end
                S_BLOCK: begin
                    if (star && c == "/") scan = S_IDLE;
                    star = (c == "*");
                end
                S_LINE: if (c == 8'h0A) scan = S_IDLE;
                S_IDENT: begin
                    if (word_lead(c) || dec_digit(c)) track_keyword(c);
                    else begin
                        close_word();
                        scan_fresh(c);
                    end
                end
                S_NUMBER: begin
                    if (dec_digit(c)) begin
                        d = 32'(c - "0");
                        if (!ovf) begin
                            if (acc > (32'hffff_ffff - d) / 10) ovf = 1;
                            else acc = acc * 10 + d;
                        end
                    end else begin
                        close_word();
                        if (scan != S_ERROR) scan_fresh(c);
                    end
                end
                S_STRING: begin
                    if (c == "\"") begin
                        slen = {1'b0, pos - tok_start} + 33'd1;
                        emit(K_STRING, tok_start, slen[32] ? 32'hffff_ffff : slen[31:0],
                             32'd0, 8'd0, E_NONE);
                        scan = S_IDLE;
                    end else if (c == "\\") scan = S_ESCAPE;
                    else emit(K_STR_BYTE, pos, 32'd1, 32'd0, c, E_NONE);
                end
                S_ESCAPE: begin
                    esc_ok = 1;
                    case (c)
                        "n": esc = 8'h0A;
                        "t": esc = 8'h09;
                        "r": esc = 8'h0D;
                        "f": esc = 8'h0C;
                        "v": esc = 8'h0B;
                        "\"": esc = "\"";
                        "\\": esc = "\\";
                        "0": esc = 8'h00;
                        default: begin
                            esc = 0;
                            esc_ok = 0;
                        end
                    endcase
                    if (!esc_ok) raise(tok_start, E_BAD_ESCAPE);
                    else begin
                        emit(K_STR_BYTE, pos - 32'd1, 32'd2, 32'd0, esc, E_NONE);
                        scan = S_STRING;
                    end
                end
                default: scan = S_ERROR;
            endcase
            pos = pos + 1;
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i]) token_q.insert(token_q.size(), step_q[i]);
    endtask

    initial begin
        fails = 0;
        reset_scan();
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            reset_scan();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.token_kind = i_out_mon.token_kind;
                got.start_offset = i_out_mon.start_offset;
                got.token_length = i_out_mon.token_length;
                got.number_value = i_out_mon.number_value;
                got.char_value = i_out_mon.char_value;
                got.error_code = i_out_mon.error_code;
                got.last = i_out_mon.last;
                if (token_q.size() == 0) begin
                    fails++;
                    $display("%0t unexpected word: actual %p", $time, got);
                end else begin
                    want = token_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_word(i_in_mon.data_byte, i_in_mon.end_of_source);
        end
    end
endmodule

// ===== bench/tb_streaming_source_tokenizer.sv =====
module tb_streaming_source_tokenizer;
    import stok_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    int   in_gap;
    logic src_done;

    stok_in_if  in_ch ();
    stok_out_if out_ch ();

    streaming_source_tokenizer uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    stok_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch.sink),
        .i_out_mon   (out_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    byte unsigned src_q[$];
    bit           eos_q[$];

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic add_byte(byte unsigned b, bit eos);
        src_q.insert(src_q.size(), b);
        eos_q.insert(eos_q.size(), eos);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i], 1'b0);
        end
    endtask

    task automatic add_end();
        add_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic string pick_piece();
        string ws[4] = '{" ", "\t", "\n", "\r"};
        string ids[12] = '{"return", "function", "var", "if", "else", "while", "break",
                           "x", "retur", "whiles", "_A9z", "funct1on"};
        string pn[7] = '{"(", ")", "{", "}", ";", ",", "="};
        string esc[9] = '{"\\n", "\\t", "\\r", "\\f", "\\v", "\\\"", "\\\\", "\\0", "\\q"};
        string s;
        int    n;
        case ($urandom_range(0, 11))
            0, 1: return ids[$urandom_range(0, 11)];
            2: begin
                n = $urandom_range(1, 11);
                s = "";
                for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(48, 57)))};
                return s;
            end
            3, 4: return pn[$urandom_range(0, 6)];
            5, 6: return ws[$urandom_range(0, 3)];
            7: begin
                s = "\"";
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                    if ($urandom_range(0, 2) == 0) s = {s, esc[$urandom_range(0, 8)]};
                    else s = {s, string'(byte'($urandom_range(32, 126)))};
                return {s, "\""};
            end
            8: return $urandom_range(0, 1) ? "/* a*b */" : "// c\n";
            9: return string'(byte'($urandom_range(0, 255)));
            default: return " ";
        endcase
    endfunction

    initial begin
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.data_byte = 0;
        in_ch.end_of_source = 0;
        out_ch.ready = 0;
        src_done = 0;

        add_text("return function var if else while break foo");
        add_end();
        add_text("4294967295 4294967296;(){},=\"a\\n\\t\\r\\f\\v\\\"\\\\\\0\"");
        add_end();
        add_text("\"x\\q\" zz"); add_end();
        add_text("/*/"); add_end();
        add_text("/ x"); add_end();
        add_text("/"); add_end();
        add_text("\"ab"); add_end();
        add_text("\"a\\"); add_end();
        add_byte(8'hff, 1'b0);
        add_byte(8'h80, 1'b0);
        add_end();
        add_end();
        while (src_q.size() < 745) begin
            if ($urandom_range(0, 15) == 0) add_end();
            else add_text(pick_piece());
        end
        add_end();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        while (src_q.size() > 0) begin
            in_ch.valid <= 1;
            in_ch.data_byte <= src_q[0];
            in_ch.end_of_source <= eos_q[0];
            do @(posedge i_clk); while (!in_ch.ready);
            void'(src_q.pop_front());
            void'(eos_q.pop_front());
            in_gap = gap_len();
            if (src_q.size() > 0 && in_gap > 0) begin
                in_ch.valid <= 0;
                in_ch.data_byte <= $urandom_range(0, 255);
                in_ch.end_of_source <= $urandom_range(0, 1);
                repeat (in_gap) @(posedge i_clk);
            end
        end
        in_ch.valid <= 0;
        src_done = 1;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            out_ch.ready <= 1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            if (gap_len() > 0) begin
                out_ch.ready <= 0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        cycles = 0;
        while (!(src_done && pending == 0)) begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 200000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
